/* sv/srmp_pkg.sv */
// Shared types, constants and the coil lookup for the stepper ramp controller.
// No dependencies; used by srmp_div and stepper_ramp_controller.
package srmp_pkg;

    localparam int POS_W          = 32;
    localparam int RAMP_W         = 8;
    localparam int PULSE_W        = 15;
    localparam int PAUSE_W        = 16;
    localparam int WAIT_W         = 26;
    localparam int COIL_W         = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_ACCEL_STEPS = 16;

    localparam int DIVISOR_W  = $clog2(MAX_ACCEL_STEPS + 2);
    localparam int DIVIDEND_W = PULSE_W + $clog2(MAX_ACCEL_STEPS + 1);
    localparam int DCNT_W     = $clog2(DIVIDEND_W);

    localparam logic [POS_W-1:0]  POS_RESET   = POS_W'(1000);
    localparam logic [WAIT_W-1:0] START_WAIT  = WAIT_W'(1000);
    localparam logic [WAIT_W-1:0] MS_TO_US    = WAIT_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_UP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_SET  = 2'd1,
        KIND_LOAD = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MAG,
        S_SUM,
        S_STEP,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    // Half-step coil sequence.
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [2:0] idx);
        logic [COIL_W-1:0] bits;
        unique case (idx)
            3'd0:    bits = 4'b1000;
            3'd1:    bits = 4'b1100;
            3'd2:    bits = 4'b0100;
            3'd3:    bits = 4'b0110;
            3'd4:    bits = 4'b0010;
            3'd5:    bits = 4'b0011;
            3'd6:    bits = 4'b0001;
            default: bits = 4'b1001;
        endcase
        return bits;
    endfunction

endpackage

/* sv/srmp_div.sv */
// Bit-serial restoring divider for the pulse time, one quotient bit per cycle.
// Depends on srmp_pkg.
module srmp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srmp_pkg::t_div_req                i_req,
    output logic                              o_done,
    output logic [srmp_pkg::DIVIDEND_W-1:0]   o_quotient
);
    import srmp_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DCNT_W-1:0]     r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;
    logic [DIVISOR_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[DIVIDEND_W-1]};
        fits    = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DCNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

/* sv/stepper_ramp_controller.sv */
// Top level of the half-step stepper controller with a linear speed ramp and waypoint.
// Depends on srmp_pkg and srmp_div.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-------------------------------------
//  item in  | in        | i_in_valid / o_in_stall   | kind, target, waypoint, phase offset
//  result   | out       | o_out_valid / i_out_stall | coils, position, target, flags, wait
//  config   | in        | i_cfg_we (no wait)        | index i_cfg_idx, data i_cfg_wdata
//
// A moving tick runs through exec, magnitude, sum and step, a divider start, the divider
// wait for 20 quotient bits and the result load; the next word is taken only after that.
// A final step or a stop skips the divider states; an idle tick, a set-target, a load
// or an unused kind goes from exec straight to the result load.
// Synchronous active-low reset restores position, target and waypoint to 1000 and
// clears the ramp, coils, active flag and registers. A stalled result word does not block
// the next input word; only that word's own result waits in the last state.
module stepper_ramp_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [srmp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [srmp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic [srmp_pkg::POS_W-1:0]          i_target_position,
    input  logic [srmp_pkg::POS_W-1:0]          i_waypoint_position,
    input  logic [2:0]                          i_phase_offset,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [srmp_pkg::COIL_W-1:0]         o_coil_pattern,
    output logic [srmp_pkg::POS_W-1:0]          o_current_position,
    output logic [srmp_pkg::POS_W-1:0]          o_target_now,
    output logic                                o_moving,
    output logic                                o_active,
    output logic [srmp_pkg::WAIT_W-1:0]         o_wait_us,
    output logic                                o_target_reached,
    output logic                                o_stopped
);
    import srmp_pkg::*;

    localparam int SW = RAMP_W + 1;
    localparam logic signed [SW-1:0] MAXS = SW'(MAX_ACCEL_STEPS);
    localparam logic signed [SW-1:0] ONES = SW'(1);

    // Configuration registers.
    logic [PULSE_W-1:0] r_fast_up;
    logic [PULSE_W-1:0] r_fast_down;
    logic [PAUSE_W-1:0] r_pause_ms;

    // Controller state.
    t_state              r_state;
    t_state              n_state;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_goal;
    logic [POS_W-1:0]    r_via;
    logic [2:0]          r_off;
    logic signed [RAMP_W-1:0] r_ramp;
    logic                r_running;
    logic [COIL_W-1:0]   r_coil;

    // Captured input word.
    logic [1:0]          r_kind;
    logic [POS_W-1:0]    r_tgt;
    logic [POS_W-1:0]    r_way;
    logic [2:0]          r_offs_in;

    // Working registers of a tick.
    logic [POS_W-1:0]    r_d;
    logic [POS_W-1:0]    r_e;
    logic [POS_W-1:0]    r_ma;
    logic [POS_W-1:0]    r_mb;
    logic [POS_W-1:0]    r_mag;
    logic                r_dir_neg;
    logic                r_dir_zero;
    logic [WAIT_W-1:0]   r_wait;
    logic                r_reached;
    logic                r_halted;

    // Output register.
    logic                r_out_valid;
    logic [COIL_W-1:0]   r_o_coil;
    logic [POS_W-1:0]    r_o_pos;
    logic [POS_W-1:0]    r_o_goal;
    logic                r_o_moving;
    logic                r_o_active;
    logic [WAIT_W-1:0]   r_o_wait;
    logic                r_o_reached;
    logic                r_o_halted;

    logic                in_accept;
    logic                out_free;
    logic                tick_go;
    logic                halt;

    // Divider interface.
    t_div_req               div_req;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  div_quo;
    logic [PULSE_W-1:0]     mult;
    logic [RAMP_W-1:0]      abs_ramp;
    logic [RAMP_W-1:0]      lim_ramp;

    // Set-target decode.
    logic [POS_W-1:0]    way_eff;
    logic                was_idle;
    logic                no_change;

    // Step arithmetic.
    logic [POS_W-1:0]    neg_e;
    logic signed [SW-1:0] s0;
    logic signed [SW-1:0] dirv;
    logic signed [SW-1:0] sd;
    logic signed [SW-1:0] sn;
    logic signed [SW-1:0] sd2;
    logic signed [SW-1:0] magv;
    logic [POS_W-1:0]    pos_new;
    logic [2:0]          coil_idx;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign tick_go   = (r_kind == KIND_TICK) && r_running;
    assign halt      = (r_mag == '0) || r_dir_zero;

    // Set target: a waypoint that equals the position is replaced by the target.
    always_comb begin
        way_eff   = (r_way == r_pos) ? r_tgt : r_way;
        was_idle  = (r_goal == r_pos) && (r_goal == r_via);
        no_change = (r_tgt == r_goal) && (way_eff == r_goal);
    end

    // Ramp one level toward the top speed in the move direction, then limit
    // the level to the remaining distance so the motor can stop in time.
    always_comb begin
        neg_e = '0 - r_e;
        s0    = {r_ramp[RAMP_W-1], r_ramp};
        dirv  = r_dir_neg ? -ONES : ONES;
        magv  = SW'(r_mag);
        sd    = r_dir_neg ? -s0 : s0;
        if (s0 == '0) begin
            sn = dirv;
        end else if (sd < MAXS) begin
            sn = s0 + dirv;
        end else begin
            sn = r_dir_neg ? -MAXS : MAXS;
        end
        sd2 = r_dir_neg ? -sn : sn;
        if (s0 != '0 && !sd2[SW-1] && (POS_W'(unsigned'(sd2)) >= r_mag)) begin
            sn = r_dir_neg ? -magv : magv;
        end
        if (sn > 0) begin
            pos_new = r_pos + 1'b1;
        end else if (sn < 0) begin
            pos_new = r_pos - 1'b1;
        end else begin
            pos_new = r_pos;
        end
        coil_idx = pos_new[2:0] + r_off;
    end

    // Pulse time operands: base time times the top level, over one plus the level.
    always_comb begin
        mult     = (r_ramp > 0) ? r_fast_up : r_fast_down;
        abs_ramp = r_ramp[RAMP_W-1] ? RAMP_W'(-r_ramp) : RAMP_W'(r_ramp);
        lim_ramp = (abs_ramp > RAMP_W'(MAX_ACCEL_STEPS)) ? RAMP_W'(MAX_ACCEL_STEPS)
                                                         : abs_ramp;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EXEC;
            S_EXEC:   n_state = tick_go ? S_MAG : S_OUT;
            S_MAG:    n_state = S_SUM;
            S_SUM:    n_state = S_STEP;
            S_STEP:   n_state = (halt || r_mag == POS_W'(1)) ? S_OUT : S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (div_done) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State-driven outputs.
    always_comb begin
        o_in_stall       = (r_state != S_IDLE);
        div_req.start    = (r_state == S_DSTART);
        div_req.dividend = DIVIDEND_W'(mult) * DIVIDEND_W'(MAX_ACCEL_STEPS);
        div_req.divisor  = DIVISOR_W'(lim_ramp) + 1'b1;
    end

    srmp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_up   <= '0;
            r_fast_down <= '0;
            r_pause_ms  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_UP)    r_fast_up   <= i_cfg_wdata[PULSE_W-1:0];
            if (i_cfg_idx == CFG_DOWN)  r_fast_down <= i_cfg_wdata[PULSE_W-1:0];
            if (i_cfg_idx == CFG_PAUSE) r_pause_ms  <= i_cfg_wdata[PAUSE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
        end else begin
            r_state   <= n_state;
        end
    end

    // Captured word and per-tick working registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind    <= i_kind;
            r_tgt     <= i_target_position;
            r_way     <= i_waypoint_position;
            r_offs_in <= i_phase_offset;
        end
        unique case (r_state)
            S_EXEC: begin
                r_d <= r_via - r_pos;
                r_e <= r_via - r_goal;
            end
            S_MAG: begin
                r_ma <= r_d[POS_W-1] ? ('0 - r_d) : r_d;
                r_mb <= r_e[POS_W-1] ? neg_e : r_e;
                if (r_d != '0) begin
                    r_dir_neg  <= r_d[POS_W-1];
                    r_dir_zero <= 1'b0;
                end else begin
                    // Waypoint already reached: the direction is toward the target.
                    r_dir_neg  <= neg_e[POS_W-1];
                    r_dir_zero <= (r_e == '0);
                end
            end
            S_SUM: begin
                r_mag <= r_ma + r_mb;
            end
            default: begin
            end
        endcase
    end

    // Controller state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_RESET;
            r_goal    <= POS_RESET;
            r_via     <= POS_RESET;
            r_off     <= '0;
            r_ramp    <= '0;
            r_running <= 1'b0;
            r_coil    <= '0;
            r_wait    <= '0;
            r_reached <= 1'b0;
            r_halted  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_wait    <= '0;
                r_reached <= 1'b0;
                r_halted  <= 1'b0;
            end
            unique case (r_state)
                S_EXEC: begin
                    if (r_kind == KIND_SET) begin
                        if (was_idle) begin
                            r_ramp <= '0;
                        end
                        if (!(was_idle && no_change)) begin
                            r_goal <= r_tgt;
                            r_via  <= way_eff;
                        end
                        if (was_idle && !no_change) begin
                            r_running <= 1'b1;
                            r_wait    <= START_WAIT;
                        end
                    end else if (r_kind == KIND_LOAD) begin
                        r_goal <= r_tgt;
                        r_via  <= r_tgt;
                        r_pos  <= r_tgt;
                        r_off  <= r_offs_in;
                    end
                end
                S_MAG: begin
                    if (r_d == '0) r_via <= r_goal;
                end
                S_STEP: begin
                    if (halt) begin
                        r_coil    <= '0;
                        r_running <= 1'b0;
                        r_halted  <= 1'b1;
                    end else begin
                        r_pos  <= pos_new;
                        if (pos_new == r_via) r_via <= r_goal;
                        r_coil <= coil_lookup(coil_idx);
                        if (r_mag == POS_W'(1)) begin
                            r_ramp    <= '0;
                            r_wait    <= WAIT_W'(r_pause_ms) * MS_TO_US;
                            r_reached <= 1'b1;
                        end else begin
                            r_ramp <= RAMP_W'(sn);
                        end
                    end
                end
                S_DWAIT: begin
                    if (div_done) r_wait <= WAIT_W'(div_quo);
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: loads when the result is complete and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_coil    <= r_coil;
            r_o_pos     <= r_pos;
            r_o_goal    <= r_goal;
            r_o_moving  <= r_running && ((r_goal != r_pos) || (r_via != r_goal));
            r_o_active  <= r_running;
            r_o_wait    <= r_wait;
            r_o_reached <= r_reached;
            r_o_halted  <= r_halted;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_coil_pattern     = r_o_coil;
    assign o_current_position = r_o_pos;
    assign o_target_now       = r_o_goal;
    assign o_moving           = r_o_moving;
    assign o_active           = r_o_active;
    assign o_wait_us          = r_o_wait;
    assign o_target_reached   = r_o_reached;
    assign o_stopped          = r_o_halted;

    // The speed level never leaves the ramp range.
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ramp <= RAMP_W'(MAX_ACCEL_STEPS)) && (r_ramp >= -RAMP_W'(MAX_ACCEL_STEPS)))
        else $error("speed level out of range");

    // Only a tick that finds no distance may drop the active flag.
    a_stop_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) |-> $past(r_state == S_STEP))
        else $error("active flag cleared outside the step state");

    // The divider reports completion only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside the wait state");

    // A result cannot both make the final step and report a stop.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_target_reached && o_stopped))
        else $error("reached and stopped both set");

    // A final step always leaves a coil pattern energized.
    a_reached_coil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_target_reached) |-> (o_coil_pattern != '0))
        else $error("final step with coils cleared");

endmodule

/* sim/stepper_ramp_controller_test.sv */
// Self-checking testbench for the half-step stepper ramp controller.
// It needs srmp_pkg and the controller RTL. A predictor in the testbench
// computes the expected result word for each accepted command word.
module stepper_ramp_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    import srmp_pkg::*;

    // Kind code 3 is not defined; the block must treat it like an idle tick.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 40;

    // Half-step coil sequence, indexed by (position + offset) mod 8.
    localparam logic [3:0] HALF_STEP_COILS [8] = '{
        4'b1000, 4'b1100, 4'b0100, 4'b0110, 4'b0010, 4'b0011, 4'b0001, 4'b1001
    };

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] tgt;
        logic [31:0] way;
        logic [2:0]  offs;
    } command_t;

    typedef struct {
        logic [3:0]  coils;
        logic [31:0] pos;
        logic [31:0] goal;
        logic        moving;
        logic        active;
        logic [25:0] wait_us;
        logic        reached;
        logic        halted;
    } report_t;

    // Motor state as the block holds it; the speed level is signed.
    typedef struct {
        logic [31:0] pos;
        logic [31:0] goal;
        logic [31:0] via;
        logic [2:0]  offs;
        int          level;
        logic        run;
        logic [3:0]  coils;
    } motor_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_kind = 2'd0;
    logic [POS_W-1:0] i_target_position = '0;
    logic [POS_W-1:0] i_waypoint_position = '0;
    logic [2:0] i_phase_offset = 3'd0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [COIL_W-1:0] o_coil_pattern;
    logic [POS_W-1:0] o_current_position;
    logic [POS_W-1:0] o_target_now;
    logic o_moving;
    logic o_active;
    logic [WAIT_W-1:0] o_wait_us;
    logic o_target_reached;
    logic o_stopped;

    stepper_ramp_controller u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_kind              (i_kind),
        .i_target_position   (i_target_position),
        .i_waypoint_position (i_waypoint_position),
        .i_phase_offset      (i_phase_offset),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_coil_pattern      (o_coil_pattern),
        .o_current_position  (o_current_position),
        .o_target_now        (o_target_now),
        .o_moving            (o_moving),
        .o_active            (o_active),
        .o_wait_us           (o_wait_us),
        .o_target_reached    (o_target_reached),
        .o_stopped           (o_stopped)
    );

    always #5 i_clk = ~i_clk;

    // Register copies used by the predictor. They only change while the block is idle.
    logic [14:0] rate_up = '0;
    logic [14:0] rate_down = '0;
    logic [15:0] pause_ms = '0;

    // Two copies of the motor state: one runs ahead while the stimulus is planned,
    // the other advances as the block accepts command words.
    motor_t plan;
    motor_t seen;

    command_t queued_words[$];
    report_t  due_reports[$];
    command_t on_bus;
    logic     in_fire = 1'b0;
    int       words_planned = 0;
    int       mismatches = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 16;
    int       recv_stall_pct = 68;

    function automatic motor_t motor_at_reset();
        motor_t m;
        m.pos = 32'd1000;
        m.goal = 32'd1000;
        m.via = 32'd1000;
        m.offs = 3'd0;
        m.level = 0;
        m.run = 1'b0;
        m.coils = 4'd0;
        return m;
    endfunction

    function automatic int heading_of(logic [31:0] d);
        if (d == 32'd0) return 0;
        return d[31] ? -1 : 1;
    endfunction

    function automatic logic [31:0] magnitude(logic [31:0] d);
        return d[31] ? (32'd0 - d) : d;
    endfunction

    // Pulse time shrinks as the speed level climbs toward the ramp limit.
    function automatic logic [25:0] pulse_us(int level);
        logic [31:0] base;
        int          speed;
        base = (level > 0) ? {17'd0, rate_up} : {17'd0, rate_down};
        speed = (level < 0) ? -level : level;
        if (speed > MAX_ACCEL_STEPS) speed = MAX_ACCEL_STEPS;
        return 26'((base * 32'(MAX_ACCEL_STEPS)) / 32'(1 + speed));
    endfunction

    // Applies one command word to a motor state and forms the result word it causes.
    function automatic void advance_motor(inout motor_t m, input command_t w,
                                          output report_t r);
        logic [31:0] gap;
        logic [31:0] span;
        logic [31:0] way;
        int          heading;
        int          lvl;
        logic        go;
        r.wait_us = '0;
        r.reached = 1'b0;
        r.halted = 1'b0;
        if (w.kind == KIND_TICK && m.run) begin
            gap = m.via - m.pos;
            heading = heading_of(gap);
            // Distance runs through the waypoint; the sum wraps at 32 bits.
            span = magnitude(gap) + magnitude(m.via - m.goal);
            if (heading == 0) begin
                m.via = m.goal;
                heading = heading_of(m.via - m.pos);
            end
            if (span == 32'd0 || heading == 0) begin
                m.coils = 4'd0;
                m.run = 1'b0;
                r.halted = 1'b1;
            end else begin
                lvl = m.level;
                if (lvl == 0) begin
                    lvl = heading;
                end else begin
                    // A level against the heading ramps down while the motor keeps
                    // moving the old way; the level never exceeds what is left.
                    if (lvl * heading < MAX_ACCEL_STEPS) lvl = lvl + heading;
                    else lvl = MAX_ACCEL_STEPS * heading;
                    if (lvl * heading >= 0 && 32'(lvl * heading) >= span)
                        lvl = heading * int'(span);
                end
                if (lvl > 0) m.pos = m.pos + 32'd1;
                else if (lvl < 0) m.pos = m.pos - 32'd1;
                if (m.pos == m.via) m.via = m.goal;
                m.coils = HALF_STEP_COILS[3'(m.pos + 32'(m.offs))];
                if (span == 32'd1) begin
                    lvl = 0;
                    r.wait_us = 26'(32'(pause_ms) * 32'd1000);
                    r.reached = 1'b1;
                end else begin
                    r.wait_us = pulse_us(lvl);
                end
                m.level = lvl;
            end
        end else if (w.kind == KIND_SET) begin
            way = (w.way == m.pos) ? w.tgt : w.way;
            go = 1'b1;
            if (m.goal == m.pos && m.goal == m.via) begin
                m.level = 0;
                if (w.tgt == m.goal && way == m.goal) begin
                    go = 1'b0;
                end else begin
                    m.run = 1'b1;
                    r.wait_us = 26'd1000;
                end
            end
            if (go) begin
                m.goal = w.tgt;
                m.via = way;
            end
        end else if (w.kind == KIND_LOAD) begin
            m.goal = w.tgt;
            m.via = w.tgt;
            m.pos = w.tgt;
            m.offs = w.offs;
        end
        r.coils = m.coils;
        r.pos = m.pos;
        r.goal = m.goal;
        r.moving = m.run && (m.goal != m.pos || m.via != m.goal);
        r.active = m.run;
    endfunction

    function automatic void queue_word(logic [1:0] kind, logic [31:0] tgt,
                                       logic [31:0] way, logic [2:0] offs);
        command_t w;
        report_t  ignored;
        w.kind = kind;
        w.tgt = tgt;
        w.way = way;
        w.offs = offs;
        advance_motor(plan, w, ignored);
        queued_words.push_back(w);
        words_planned++;
    endfunction

    // Ticks carry junk in the unused fields so that every input bit toggles.
    function automatic void queue_tick();
        queue_word(KIND_TICK, $urandom, $urandom, 3'($urandom));
    endfunction

    function automatic logic [31:0] pick_position();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($urandom_range(200));
            2:       return 32'hFFFF_FF00 + 32'($urandom_range(255));
            default: return 32'h7FFF_FF80 + 32'($urandom_range(255));
        endcase
    endfunction

    // Ticks the planned motor until it goes inactive, with the odd retarget, load or
    // junk word thrown in. A move that outlives the cap is ended by a load.
    function automatic void run_out(int cap);
        logic [31:0] tgt;
        int          n;
        n = 0;
        while (plan.run && n < cap) begin
            case ($urandom_range(199))
                0, 1, 2: begin
                    tgt = plan.pos + 32'($urandom_range(60)) - 32'd30;
                    queue_word(KIND_SET, tgt, $urandom_range(1) ? tgt : plan.pos,
                               3'($urandom));
                end
                3: queue_word(KIND_UNUSED, $urandom, $urandom, 3'($urandom));
                4: queue_word(KIND_LOAD, pick_position(), $urandom, 3'($urandom));
                default: ;
            endcase
            queue_tick();
            n++;
        end
        if (plan.run) begin
            queue_word(KIND_LOAD, plan.pos, $urandom, plan.offs);
            queue_tick();
        end
    endfunction

    // One move: mostly a set-target with a nearby goal, sometimes via a waypoint
    // past the goal or on the far side, then ticks until the move ends.
    function automatic void plan_move();
        logic [31:0] tgt;
        logic [31:0] way;
        logic [31:0] over;
        logic        up;
        int          reach;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            queue_word(KIND_LOAD, pick_position(), $urandom, 3'($urandom));
        end else if (pick < 16) begin
            queue_word(KIND_UNUSED, $urandom, $urandom, 3'($urandom));
            queue_tick();
            return;
        end else if (pick < 20) begin
            // A move to anywhere, cut short by a load at some random point.
            queue_word(KIND_SET, $urandom, $urandom, 3'($urandom));
            repeat ($urandom_range(1, 12)) queue_tick();
            queue_word(KIND_LOAD, pick_position(), $urandom, 3'($urandom));
            queue_tick();
            return;
        end
        reach = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
        up = $urandom_range(1);
        tgt = up ? plan.pos + 32'(reach) : plan.pos - 32'(reach);
        over = 32'($urandom_range(1, 20));
        case ($urandom_range(9))
            0, 1, 2, 3: way = tgt;
            4, 5, 6:    way = up ? tgt + over : tgt - over;
            7, 8:       way = up ? plan.pos - over : plan.pos + over;
            default:    way = plan.pos;
        endcase
        queue_word(KIND_SET, tgt, way, 3'($urandom));
        run_out(1500);
        if ($urandom_range(3) == 0) queue_tick();
    endfunction

    function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Waits until every planned word is taken and every result word has come back.
    task automatic settle();
        do @(posedge i_clk);
        while (queued_words.size() != 0 || i_in_valid || due_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_UP:   rate_up = data[14:0];
            CFG_DOWN: rate_down = data[14:0];
            default:  pause_ms = data;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Driver: presents the next queued word on the falling edge once the previous
    // one was taken, and throws random stalls at the result channel.
    always @(negedge i_clk) begin
        command_t w;
        if (i_rst_n) begin
            if (!i_in_valid || in_fire) begin
                if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = queued_words.pop_front();
                    on_bus = w;
                    i_kind <= w.kind;
                    i_target_position <= w.tgt;
                    i_waypoint_position <= w.way;
                    i_phase_offset <= w.offs;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: checks each result word taken on this edge, then predicts the result
    // of any command word taken on the same edge.
    always @(posedge i_clk) begin
        report_t want;
        report_t got;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_reports.size() == 0) begin
                    $error("result word arrived with no command outstanding");
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    match_field("coil_pattern", 32'(want.coils), 32'(o_coil_pattern));
                    match_field("current_position", want.pos, o_current_position);
                    match_field("target_now", want.goal, o_target_now);
                    match_field("moving", 32'(want.moving), 32'(o_moving));
                    match_field("active", 32'(want.active), 32'(o_active));
                    match_field("wait_us", 32'(want.wait_us), 32'(o_wait_us));
                    match_field("target_reached", 32'(want.reached), 32'(o_target_reached));
                    match_field("stopped", 32'(want.halted), 32'(o_stopped));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                advance_motor(seen, on_bus, got);
                due_reports.push_back(got);
            end
            in_fire <= i_in_valid && !o_in_stall;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int seg;
        plan = motor_at_reset();
        seen = motor_at_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words, all registers still zero so every wait comes out 0 or 1000.
        queue_tick();                                           // tick while inactive
        queue_word(KIND_UNUSED, '1, '1, 3'd7);                  // undefined kind
        queue_word(KIND_SET, 32'd1000, 32'd1000, 3'd0);         // same target, no start
        queue_word(KIND_SET, 32'd1003, 32'd1000, 3'd5);         // waypoint at position
        run_out(10);
        queue_tick();
        queue_word(KIND_LOAD, 32'hFFFF_FFFF, 32'd0, 3'd7);
        queue_word(KIND_SET, 32'd1, 32'd3, 3'd0);               // up across the wrap
        run_out(40);
        queue_word(KIND_LOAD, 32'd0, '1, 3'd3);
        // Both legs of the waypoint are half the number circle: the distance sum
        // wraps to zero and the first tick stops short of the waypoint.
        queue_word(KIND_SET, 32'd0, 32'h8000_0000, 3'd0);
        queue_tick();
        queue_tick();
        queue_word(KIND_SET, 32'd5, 32'd5, 3'd0);               // ignored start, not idle
        queue_tick();
        queue_word(KIND_LOAD, 32'hFFFF_FFFE, 32'd0, 3'd0);
        queue_word(KIND_SET, 32'hFFFF_FFF0, 32'hFFFF_FFFE, 3'd0);
        run_out(40);
        settle();

        for (seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 16;
                    recv_stall_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_stall_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (seg)
                0: begin
                    write_reg(CFG_UP, 16'h7FFF);
                    write_reg(CFG_DOWN, 16'h7FFF);
                    write_reg(CFG_PAUSE, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_UP, 16'd1);
                    write_reg(CFG_DOWN, 16'd0);
                    write_reg(CFG_PAUSE, 16'd1);
                end
                3: begin
                    write_reg(CFG_UP, 16'd0);
                    write_reg(CFG_DOWN, 16'h7FFF);
                    write_reg(CFG_PAUSE, 16'd0);
                end
                5: begin
                    // The top data bit lies outside the pulse registers.
                    write_reg(CFG_UP, 16'hFFFF);
                    write_reg(CFG_DOWN, 16'h8000 | 16'($urandom_range(32767)));
                    write_reg(CFG_PAUSE, 16'($urandom));
                end
                default: begin
                    write_reg(CFG_UP, 16'($urandom));
                    write_reg(CFG_DOWN, 16'($urandom));
                    write_reg(CFG_PAUSE, 16'($urandom));
                end
            endcase
            while (words_planned < 30 + (seg + 1) * 305) plan_move();
            settle();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
sv/srmp_pkg.sv
sv/srmp_div.sv
sv/stepper_ramp_controller.sv
sim/stepper_ramp_controller_test.sv
